[rtl/core/hufw_pkg.sv]
// ----------------------------------------------------------------------------
// hufw_pkg
// Shared types and constants of the tree-walk Huffman decoder.
// ----------------------------------------------------------------------------
package hufw_pkg;

  localparam int unsigned NODE_W        = 6;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TOP_BIT       = 7;
  localparam int unsigned BITS_PER_BYTE = TOP_BIT + 1;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
  localparam int unsigned ENTRY_W       = 2 * NODE_W + SYM_W;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_INDEX       = 1'b0,
    REG_MAX_OUTPUT_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  symbol;
  } node_t;

  // walk -> result stage
  typedef struct packed {
    logic               push;
    logic               flush;
    logic [SYM_W-1:0]   symbol;
    logic [COUNT_W-1:0] count;
  } emit_t;

endpackage

[rtl/core/hufw_cfg_if.sv]
// ----------------------------------------------------------------------------
// hufw_cfg_if
// Register write channel: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hufw_cfg_if;
  import hufw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/hufw_in_if.sv]
// ----------------------------------------------------------------------------
// hufw_in_if
// Input item channel: node loads, data bytes and stream restarts.
// ----------------------------------------------------------------------------
interface hufw_in_if;
  import hufw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] node_addr;
  logic [NODE_W-1:0] node_left;
  logic [NODE_W-1:0] node_right;
  logic [SYM_W-1:0]  node_symbol;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output operation, output node_addr, output node_left,
                  output node_right, output node_symbol, output data_byte, input ready);
  modport sink   (input valid, input operation, input node_addr, input node_left,
                  input node_right, input node_symbol, input data_byte, output ready);
endinterface

[rtl/core/hufw_out_if.sv]
// ----------------------------------------------------------------------------
// hufw_out_if
// Result channel: decoded symbol, running count and end-of-byte mark.
// ----------------------------------------------------------------------------
interface hufw_out_if;
  import hufw_pkg::*;

  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   symbol;
  logic [COUNT_W-1:0] output_count;
  logic               last;

  modport source (output valid, output symbol, output output_count, output last,
                  input ready);
  modport sink   (input valid, input symbol, input output_count, input last,
                  output ready);
endinterface

[rtl/core/hufw_ram.sv]
// ----------------------------------------------------------------------------
// hufw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hufw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/hufw_walk.sv]
// ----------------------------------------------------------------------------
// hufw_walk
// Node table and bit-serial tree walk: one data bit shifts out per cycle,
// held by root fetches and output stalls; each bit picks the child read next.
// ----------------------------------------------------------------------------
module hufw_walk #(
  parameter int NODE_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  hufw_in_if.sink                       in_ch,
  input  logic [hufw_pkg::NODE_W-1:0]   root_index,
  input  logic [hufw_pkg::COUNT_W-1:0]  max_count,
  input  logic                          res_ready,
  output hufw_pkg::emit_t               emit
);
  import hufw_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  state_t                 state, state_next;
  logic [NODE_W-1:0]      cur_node;
  logic [BYTE_W-1:0]      shreg;
  logic [BIT_CNT_W-1:0]   bits_left;
  logic                   check_pending;
  logic [COUNT_W-1:0]     count;
  logic                   rd_in_range;
  logic [ENTRY_W-1:0]     rd_data;
  node_t                  entry;
  node_t                  load_entry;

  logic                   accept;
  logic                   leaf_hit;
  logic                   more_bits;
  logic [NODE_W-1:0]      child;
  logic                   we;
  logic                   re;
  logic [NODE_W-1:0]      raddr_node;
  logic                   do_step;
  logic                   do_emit;

  function automatic logic in_table(input logic [NODE_W-1:0] n);
    return 32'(n) < NODE_COUNT;
  endfunction

  assign accept     = in_ch.valid && in_ch.ready;
  assign entry      = rd_in_range ? node_t'(rd_data) : '0;
  assign leaf_hit   = check_pending && (entry.symbol != '0) && (count < max_count);
  assign more_bits  = bits_left != '0;
  assign child      = shreg[BYTE_W-1] ? entry.right : entry.left;

  assign load_entry = '{left: in_ch.node_left, right: in_ch.node_right,
                        symbol: in_ch.node_symbol};
  assign we         = accept && (in_ch.operation == OP_LOAD) && in_table(in_ch.node_addr);

  hufw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_ch.node_addr)),
    .wdata (load_entry),
    .re    (re),
    .raddr (AW'(raddr_node)),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_ch.operation == OP_DECODE)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!leaf_hit && !more_bits && res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    re          = 1'b0;
    raddr_node  = cur_node;
    do_step     = 1'b0;
    do_emit     = 1'b0;
    emit.push   = 1'b0;
    emit.flush  = 1'b0;
    emit.symbol = entry.symbol;
    emit.count  = count + COUNT_W'(1);
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept && (in_ch.operation == OP_DECODE)) begin
          re = 1'b1;
        end
      end
      ST_WALK: begin
        if (leaf_hit) begin
          // emit and fetch the root entry for the next bit; hold when blocked
          if (res_ready) begin
            do_emit    = 1'b1;
            emit.push  = 1'b1;
            re         = 1'b1;
            raddr_node = root_index;
          end
        end else if (more_bits) begin
          do_step    = 1'b1;
          re         = 1'b1;
          raddr_node = child;
        end else begin
          emit.flush = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur_node      <= '0;
      count         <= '0;
      check_pending <= 1'b0;
      bits_left     <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (in_ch.operation)
          OP_RESTART: begin
            cur_node <= root_index;
            count    <= '0;
          end
          OP_DECODE: begin
            bits_left     <= BIT_CNT_W'(BITS_PER_BYTE);
            check_pending <= 1'b0;
          end
          default: ;
        endcase
      end
      if (do_step) begin
        cur_node      <= child;
        bits_left     <= bits_left - BIT_CNT_W'(1);
        check_pending <= 1'b1;
      end
      if (do_emit) begin
        cur_node      <= root_index;
        count         <= count + COUNT_W'(1);
        check_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_ch.operation == OP_DECODE)) begin
      shreg <= in_ch.data_byte;
    end else if (do_step) begin
      shreg <= {shreg[BYTE_W-2:0], 1'b0};
    end
    // nodes past the table read as an inner node with both children zero
    if (re) begin
      rd_in_range <= in_table(raddr_node);
    end
  end

endmodule

[rtl/core/hufw_result.sv]
// ----------------------------------------------------------------------------
// hufw_result
// Result staging: one symbol is held back until the next symbol or the end of
// the byte shows whether it is the last, then moves to the output register.
// ----------------------------------------------------------------------------
module hufw_result (
  input  logic            clk,
  input  logic            rst,
  input  hufw_pkg::emit_t emit,
  output logic            res_ready,
  hufw_out_if.source      out_ch
);
  import hufw_pkg::*;

  logic               pend_valid;
  logic [SYM_W-1:0]   pend_sym;
  logic [COUNT_W-1:0] pend_count;
  logic               out_valid;
  logic [SYM_W-1:0]   out_sym;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;

  logic               out_free;
  logic               push_ok;
  logic               move;

  assign out_free  = !out_valid || out_ch.ready;
  assign res_ready = !pend_valid || out_free;
  assign push_ok   = emit.push && res_ready;
  assign move      = pend_valid && out_free && (emit.push || emit.flush);

  assign out_ch.valid        = out_valid;
  assign out_ch.symbol       = out_sym;
  assign out_ch.output_count = out_count;
  assign out_ch.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (push_ok) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_sym   <= pend_sym;
      out_count <= pend_count;
      // a flush means no further symbol follows in this byte
      out_last  <= emit.flush;
    end
    if (push_ok) begin
      pend_sym   <= emit.symbol;
      pend_count <= emit.count;
    end
  end

endmodule

[rtl/core/huffman_tree_walk_decoder_top.sv]
// Load, restart and ignored items complete in the cycle they are taken.
// A data byte keeps the input busy until its walk ends: one table read per bit, one
// root read per emitted symbol (up to 8 symbols), plus output stalls.
// Each symbol reaches the output when the next one is found or the byte ends.
// Reset (rst, synchronous) clears walk position, count, registers and handshakes;
// the node table is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top
// Huffman decoder walking a loaded code tree one data bit per cycle, save for stalls.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top #(
  parameter int NODE_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  hufw_cfg_if.sink    cfg_ch,
  hufw_in_if.sink     in_ch,
  hufw_out_if.source  out_ch
);
  import hufw_pkg::*;

  logic [NODE_W-1:0]  root_index;
  logic [COUNT_W-1:0] max_count;
  logic               res_ready;
  emit_t              emit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_index <= '0;
      max_count  <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        REG_ROOT_INDEX:       root_index <= cfg_ch.wdata[NODE_W-1:0];
        REG_MAX_OUTPUT_COUNT: max_count  <= cfg_ch.wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  hufw_walk #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .root_index (root_index),
    .max_count  (max_count),
    .res_ready  (res_ready),
    .emit       (emit)
  );

  hufw_result u_result (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

[rtl/core/hufw_checker.sv]
// ----------------------------------------------------------------------------
// hufw_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hufw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [hufw_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hufw_pkg::SYM_W-1:0]    out_symbol,
  input logic [hufw_pkg::COUNT_W-1:0]  out_count,
  input logic                          out_last
);
  import hufw_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // a data byte occupies the walk and holds the input not ready
  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_operation == OP_DECODE) |=> !in_ready)
    else $error("input taken right after a data byte");

  // every other item completes in the cycle it is taken
  a_single_cycle: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_operation != OP_DECODE) |=> in_ready)
    else $error("input not ready after a single-cycle item");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count != '0))
    else $error("result with zero output count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_symbol) && $stable(out_count) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind huffman_tree_walk_decoder_top hufw_checker u_hufw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_symbol   (out_ch.symbol),
  .out_count    (out_ch.output_count),
  .out_last     (out_ch.last)
);

[test/huffman_tree_walk_decoder_top_test.sv]
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top_test
// Self-checking bench for the tree-walk Huffman decoder. A short table of
// directed items runs first: field extremes, every operation and the count
// limit, with expected results written where obvious. Random phases follow.
// Each phase reloads a random full code tree now and then, sets root and
// limit, and sends data bytes mixed with restarts and node overwrites. Both
// channels pause at random. Every symbol is checked against an in-bench
// prediction of the walk or a fixed expected result.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hufw_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 450;
  localparam int DRAIN_CYCLES  = 24;
  localparam int USE_PREDICTOR = -1;
  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [NODE_W-1:0] node_addr;
    logic [NODE_W-1:0] node_left;
    logic [NODE_W-1:0] node_right;
    logic [SYM_W-1:0]  node_symbol;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [COUNT_W-1:0] count;
    logic               last;
  } symbol_result_t;

  typedef struct {
    bit                    is_write;
    reg_idx_t              reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    int                    fixed_results;
    symbol_result_t        fixed;
  } row_t;

  logic clk;
  logic rst;

  hufw_cfg_if cfg_ch ();
  hufw_in_if  in_ch ();
  hufw_out_if out_ch ();

  huffman_tree_walk_decoder_top #(
    .NODE_COUNT (TABLE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder state as the bench sees it
  logic [NODE_W-1:0]  tree_left   [TABLE_DEPTH];
  logic [NODE_W-1:0]  tree_right  [TABLE_DEPTH];
  logic [SYM_W-1:0]   tree_symbol [TABLE_DEPTH];
  logic [NODE_W-1:0]  walk_node;
  logic [COUNT_W-1:0] stream_count;
  logic [NODE_W-1:0]  cfg_root;
  logic [COUNT_W-1:0] cfg_limit;

  symbol_result_t pending_symbols [$];
  row_t           directed_rows [$];
  int             fail_count;
  int             items_sent;
  bit             in_gaps_on;
  bit             out_stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Walk the stored tree for one item and collect the symbols it emits
  function automatic void decode_walk(input in_item_t it, ref symbol_result_t found[$]);
    symbol_result_t res;
    case (it.operation)
      OP_LOAD: begin
        tree_left[it.node_addr]   = it.node_left;
        tree_right[it.node_addr]  = it.node_right;
        tree_symbol[it.node_addr] = it.node_symbol;
      end
      OP_RESTART: begin
        walk_node    = cfg_root;
        stream_count = '0;
      end
      OP_DECODE: begin
        for (int b = TOP_BIT; b >= 0; b--) begin
          walk_node = it.data_byte[b] ? tree_right[walk_node] : tree_left[walk_node];
          if (tree_symbol[walk_node] != '0 && stream_count < cfg_limit) begin
            stream_count = stream_count + 1'b1;
            res.symbol   = tree_symbol[walk_node];
            res.count    = stream_count;
            res.last     = 1'b0;
            found.push_back(res);
            walk_node = cfg_root;
          end
        end
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation   = OP_W'($urandom);
    it.node_addr   = NODE_W'($urandom);
    it.node_left   = NODE_W'($urandom);
    it.node_right  = NODE_W'($urandom);
    it.node_symbol = SYM_W'($urandom);
    it.data_byte   = BYTE_W'($urandom);
    return it;
  endfunction

  function automatic row_t item_row(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] addr,
                                    input logic [NODE_W-1:0] left, input logic [NODE_W-1:0] right,
                                    input logic [SYM_W-1:0] sym, input logic [BYTE_W-1:0] data,
                                    input int n_fixed, input logic [SYM_W-1:0] fixed_sym,
                                    input logic [COUNT_W-1:0] fixed_count);
    row_t r;
    r.is_write         = 1'b0;
    r.reg_index        = REG_ROOT_INDEX;
    r.wdata            = '0;
    r.item.operation   = op;
    r.item.node_addr   = addr;
    r.item.node_left   = left;
    r.item.node_right  = right;
    r.item.node_symbol = sym;
    r.item.data_byte   = data;
    r.fixed_results    = n_fixed;
    r.fixed.symbol     = fixed_sym;
    r.fixed.count      = fixed_count;
    r.fixed.last       = 1'b1;
    return r;
  endfunction

  function automatic row_t write_row(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    row_t r;
    r           = item_row(OP_RESTART, '0, '0, '0, '0, '0, 0, '0, '0);
    r.is_write  = 1'b1;
    r.reg_index = idx;
    r.wdata     = value;
    return r;
  endfunction

  task automatic send_item(input in_item_t it, input int n_fixed, input symbol_result_t fixed);
    symbol_result_t found [$];
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.operation;
    in_ch.node_addr   <= it.node_addr;
    in_ch.node_left   <= it.node_left;
    in_ch.node_right  <= it.node_right;
    in_ch.node_symbol <= it.node_symbol;
    in_ch.data_byte   <= it.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    decode_walk(it, found);
    if (n_fixed == USE_PREDICTOR) begin
      foreach (found[i]) pending_symbols.push_back(found[i]);
    end else if (n_fixed > 0) begin
      pending_symbols.push_back(fixed);
    end
  endtask

  task automatic input_pause();
    int g;
    g = in_gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Registers change only with the decoder idle
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ROOT_INDEX:       cfg_root  = value[NODE_W-1:0];
      REG_MAX_OUTPUT_COUNT: cfg_limit = value;
      default: ;
    endcase
  endtask

  // Load a random full binary code tree; fill the rest of the table with
  // random nodes when the whole table is asked for
  task automatic load_tree(input bit whole_table, output logic [NODE_W-1:0] tree_root);
    logic [NODE_W-1:0] order [TABLE_DEPTH];
    node_t             shape [TABLE_DEPTH];
    logic [NODE_W-1:0] leaves [$];
    logic [NODE_W-1:0] tmp;
    logic [NODE_W-1:0] n;
    in_item_t          it;
    symbol_result_t    none;
    int                inner;
    int                used;
    int                pick;
    int                j;
    int                n_load;
    none = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) order[i] = NODE_W'(i);
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    inner = $urandom_range(1, TABLE_DEPTH / 2 - 1);
    leaves.push_back(order[0]);
    used = 1;
    for (int i = 0; i < inner; i++) begin
      pick = $urandom_range(0, leaves.size() - 1);
      n    = leaves[pick];
      leaves.delete(pick);
      shape[n].left   = order[used];
      shape[n].right  = order[used+1];
      shape[n].symbol = '0;
      leaves.push_back(order[used]);
      leaves.push_back(order[used+1]);
      used += 2;
    end
    foreach (leaves[i]) begin
      shape[leaves[i]].left   = NODE_W'($urandom);
      shape[leaves[i]].right  = NODE_W'($urandom);
      shape[leaves[i]].symbol = SYM_W'($urandom_range(1, 255));
    end
    for (int i = used; i < TABLE_DEPTH; i++) begin
      shape[order[i]].left   = NODE_W'($urandom);
      shape[order[i]].right  = NODE_W'($urandom);
      shape[order[i]].symbol = SYM_W'($urandom);
    end
    n_load = whole_table ? TABLE_DEPTH : used;
    for (int i = 0; i < n_load; i++) begin
      it             = random_item();
      it.operation   = OP_LOAD;
      it.node_addr   = order[i];
      it.node_left   = shape[order[i]].left;
      it.node_right  = shape[order[i]].right;
      it.node_symbol = shape[order[i]].symbol;
      send_item(it, USE_PREDICTOR, none);
      input_pause();
      items_sent++;
    end
    tree_root = order[0];
  endtask

  initial begin : ready_driver
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_stalls_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : symbol_check
    symbol_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_symbols.size() == 0) begin
        $error("symbol: expected none, got %0d (count %0d)", out_ch.symbol, out_ch.output_count);
        fail_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_ch.symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_ch.symbol);
          fail_count++;
        end
        if (out_ch.output_count !== want.count) begin
          $error("output_count: expected %0d, got %0d", want.count, out_ch.output_count);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t              row;
    in_item_t          it;
    symbol_result_t    none;
    logic [NODE_W-1:0] tree_root;
    logic [NODE_W-1:0] root_pick;
    logic [COUNT_W-1:0] limit_pick;
    int                phase_len;
    int                pick;
    bit                first_phase;

    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_LOAD;
    in_ch.node_addr   = '0;
    in_ch.node_left   = '0;
    in_ch.node_right  = '0;
    in_ch.node_symbol = '0;
    in_ch.data_byte   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = REG_ROOT_INDEX;
    cfg_ch.wdata      = '0;
    walk_node         = '0;
    stream_count      = '0;
    cfg_root          = '0;
    cfg_limit         = '0;
    fail_count        = 0;
    items_sent        = 0;
    in_gaps_on        = 1'b1;
    out_stalls_on     = 1'b1;
    none              = '0;
    tree_root         = '0;

    // Small tree: 0 -> (1, 2), 2 -> (3, 1); leaves 1, 3 and 63
    directed_rows.push_back(item_row(OP_LOAD, 6'd0, 6'd1, 6'd2, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_LOAD, 6'd1, 6'd0, 6'd0, 8'h41, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_LOAD, 6'd2, 6'd3, 6'd1, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_LOAD, 6'd3, 6'd0, 6'd63, 8'h01, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_LOAD, 6'd63, 6'd63, 6'd63, 8'hFF, 8'h00, 0, '0, '0));
    // undefined operation must not touch node 63
    directed_rows.push_back(item_row(OP_UNDEFINED, 6'd63, 6'd0, 6'd0, 8'h5A, 8'hFF, 0, '0, '0));
    // limit still zero from reset: leaves emit nothing
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'hFF, 0, '0, '0));
    directed_rows.push_back(item_row(OP_RESTART, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(write_row(REG_MAX_OUTPUT_COUNT, 32'hFFFF_FFFF));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00,
                                     USE_PREDICTOR, '0, '0));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'hFF,
                                     USE_PREDICTOR, '0, '0));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'hA5,
                                     USE_PREDICTOR, '0, '0));
    // new root applies from the next leaf on
    directed_rows.push_back(write_row(REG_ROOT_INDEX, 32'd2));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'h5A,
                                     USE_PREDICTOR, '0, '0));
    directed_rows.push_back(item_row(OP_RESTART, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(write_row(REG_MAX_OUTPUT_COUNT, 32'd3));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00,
                                     USE_PREDICTOR, '0, '0));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'hFF,
                                     USE_PREDICTOR, '0, '0));
    directed_rows.push_back(write_row(REG_ROOT_INDEX, 32'd63));
    directed_rows.push_back(write_row(REG_MAX_OUTPUT_COUNT, 32'd1));
    directed_rows.push_back(item_row(OP_RESTART, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 0, '0, '0));
    directed_rows.push_back(item_row(OP_DECODE, 6'd0, 6'd0, 6'd0, 8'h00, 8'hFF,
                                     1, 8'hFF, 32'd1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        write_reg(row.reg_index, row.wdata);
      end else begin
        send_item(row.item, row.fixed_results, row.fixed);
        input_pause();
      end
    end

    items_sent  = 0;
    first_phase = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      // full table first, so no walk can ever reach an unloaded node
      if (first_phase || $urandom_range(0, 3) == 0) begin
        load_tree(first_phase, tree_root);
        first_phase = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)       root_pick = tree_root;
      else if (pick == 7) root_pick = NODE_W'($urandom);
      else if (pick == 8) root_pick = '0;
      else                root_pick = '1;
      write_reg(REG_ROOT_INDEX, CFG_DATA_W'(root_pick));
      pick = $urandom_range(0, 9);
      if (pick == 0)      limit_pick = '0;
      else if (pick < 5)  limit_pick = COUNT_W'($urandom_range(1, 40));
      else if (pick < 8)  limit_pick = '1;
      else if (pick == 8) limit_pick = COUNT_W'($urandom);
      else                limit_pick = COUNT_W'($urandom_range(1, 4));
      write_reg(REG_MAX_OUTPUT_COUNT, limit_pick);

      phase_len = $urandom_range(15, 45);
      for (int i = 0; i < phase_len && items_sent < RANDOM_ITEMS; i++) begin
        it   = random_item();
        pick = $urandom_range(0, 99);
        if (i == 0 && pick < 80) it.operation = OP_RESTART;
        else if (pick < 78)      it.operation = OP_DECODE;
        else if (pick < 86)      it.operation = OP_RESTART;
        else if (pick < 94)      it.operation = OP_LOAD;
        else                     it.operation = OP_UNDEFINED;
        send_item(it, USE_PREDICTOR, none);
        input_pause();
        if (it.operation != OP_UNDEFINED) items_sent++;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_symbols.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/hufw_pkg.sv
rtl/core/hufw_cfg_if.sv
rtl/core/hufw_in_if.sv
rtl/core/hufw_out_if.sv
rtl/core/hufw_ram.sv
rtl/core/hufw_walk.sv
rtl/core/hufw_result.sv
rtl/core/huffman_tree_walk_decoder_top.sv
rtl/core/hufw_checker.sv
test/huffman_tree_walk_decoder_top_test.sv
